>>> hw/rtl/cdq_pkg.sv
// Shared constants and types for the circular deque unit.
`default_nettype none

package cdq_pkg;

  // Default number of entries the deque can hold
  localparam int unsigned DepthDefault = 8;

  // Data word width
  localparam int unsigned DataWidth = 32;

  // Request codes
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd0;
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [1:0] REQ_POP_BACK   = 2'd2;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd3;

  // Per-cycle command broadcast to every cell of one chain. The near end is
  // cell 0 of the chain, the far end is its last occupied cell.
  typedef struct packed {
    logic near_push;   // shift toward the far end, insert at cell 0
    logic near_pop;    // shift toward cell 0, drop cell 0
    logic far_push;    // write the element after the last occupied cell
    logic far_pop;     // clear the last occupied cell
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/cdq_cell.sv
// One storage cell of a deque chain: a data word and an occupied flag.
`default_nettype none

module cdq_cell (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cdq_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [cdq_pkg::DataWidth-1:0] element,
  input  wire logic signed [cdq_pkg::DataWidth-1:0] left_value,
  input  wire logic                              left_valid,
  input  wire logic signed [cdq_pkg::DataWidth-1:0] right_value,
  input  wire logic                              right_valid,
  output logic signed [cdq_pkg::DataWidth-1:0]   value,
  output logic                                   valid,
  output logic signed [cdq_pkg::DataWidth-1:0]   value_next,
  output logic                                   valid_next
);

  logic is_append;
  logic is_last;

  // This cell is the first free one, or the last occupied one
  assign is_append = left_valid & ~valid;
  assign is_last   = valid & ~right_valid;

  // Select the next contents from the neighbors or the broadcast element
  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.near_push) begin
      value_next = left_value;
      valid_next = left_valid;
    end else if (ctrl.near_pop) begin
      value_next = right_value;
      valid_next = right_valid;
    end else if (ctrl.far_push && is_append) begin
      value_next = element;
      valid_next = 1'b1;
    end else if (ctrl.far_pop && is_last) begin
      valid_next = 1'b0;
    end
  end

  // Occupied flag resets; the data word does not need to
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/cdq_chain.sv
// Row of deque cells with its near end at cell 0.
`default_nettype none

module cdq_chain #(
  parameter int unsigned DEPTH = cdq_pkg::DepthDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cdq_pkg::cell_ctrl_t               ctrl,
  input  wire logic signed [cdq_pkg::DataWidth-1:0] element,
  output logic signed [cdq_pkg::DataWidth-1:0]   head_value,
  output logic                                   head_valid,
  output logic                                   last_valid,
  output logic signed [cdq_pkg::DataWidth-1:0]   head_value_next,
  output logic                                   head_valid_next,
  output logic                                   last_valid_next
);

  logic signed [cdq_pkg::DataWidth-1:0] value      [DEPTH];
  logic                                 valid      [DEPTH];
  logic signed [cdq_pkg::DataWidth-1:0] value_next [DEPTH];
  logic                                 valid_next [DEPTH];

  // Build the row; cell 0 sees the element as its left neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [cdq_pkg::DataWidth-1:0] left_value;
    logic                                 left_valid;
    logic signed [cdq_pkg::DataWidth-1:0] right_value;
    logic                                 right_valid;

    if (i == 0) begin : g_first
      assign left_value = element;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_value = value[i-1];
      assign left_valid = valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_value = value[i+1];
      assign right_valid = valid[i+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .element     (element),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (value[i]),
      .valid       (valid[i]),
      .value_next  (value_next[i]),
      .valid_next  (valid_next[i])
    );
  end

  // Expose the fixed taps at both ends of the row
  assign head_value      = value[0];
  assign head_valid      = valid[0];
  assign last_valid      = valid[DEPTH-1];
  assign head_value_next = value_next[0];
  assign head_valid_next = valid_next[0];
  assign last_valid_next = valid_next[DEPTH-1];

endmodule

`default_nettype wire

>>> hw/rtl/circular_deque_unit.sv
// Top level of the circular deque unit: request decode, two cell rows, result register.
`default_nettype none

// Double-ended queue of up to DEPTH signed 32-bit words. Each request pushes
// or pops at the front or the back; a push while full or a pop while empty is
// refused with ok low and leaves the contents unchanged. The contents live in
// two rows of DEPTH cells that shift in parallel: one keeps the front entry
// in its first cell, the other keeps the back entry in its first cell, so
// every value reported comes from a fixed cell and no row is ever searched.
// Each request is accepted and its result is registered on the same edge,
// and a new request is taken every cycle as long as the result register is
// empty or being drained; the cell rows update in parallel. After reset the
// deque is empty and ready at once; no clearing pass is needed.
module circular_deque_unit #(
  parameter int unsigned DEPTH = cdq_pkg::DepthDefault
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        req_type,
  input  wire logic signed [cdq_pkg::DataWidth-1:0] element,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   ok,
  output logic signed [cdq_pkg::DataWidth-1:0]   popped_value,
  output logic signed [cdq_pkg::DataWidth-1:0]   front_value,
  output logic signed [cdq_pkg::DataWidth-1:0]   back_value,
  output logic                                   is_empty,
  output logic                                   is_full
);

  logic                 in_accept;
  logic                 is_push;
  logic                 req_ok;
  logic                 nonempty;
  logic                 full;
  cdq_pkg::cell_ctrl_t  front_ctrl;
  cdq_pkg::cell_ctrl_t  back_ctrl;

  logic signed [cdq_pkg::DataWidth-1:0] fr_head_value;
  logic                                 fr_head_valid;
  logic                                 fr_last_valid;
  logic signed [cdq_pkg::DataWidth-1:0] fr_head_value_next;
  logic                                 fr_head_valid_next;
  logic                                 fr_last_valid_next;
  logic signed [cdq_pkg::DataWidth-1:0] bk_head_value;
  logic                                 bk_head_valid;
  logic                                 bk_last_valid;
  logic signed [cdq_pkg::DataWidth-1:0] bk_head_value_next;

  // Hold input while a finished result waits and the consumer stalls
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Decide whether the request can proceed
  assign nonempty = fr_head_valid;
  assign full     = fr_last_valid;
  assign is_push  = (req_type == cdq_pkg::REQ_PUSH_BACK) ||
                    (req_type == cdq_pkg::REQ_PUSH_FRONT);
  assign req_ok   = is_push ? ~full : nonempty;

  // Issue row commands; the back row sees front and back swapped
  always_comb begin
    front_ctrl = '0;
    back_ctrl  = '0;
    if (in_accept && req_ok) begin
      case (req_type)
        cdq_pkg::REQ_PUSH_BACK: begin
          front_ctrl.far_push  = 1'b1;
          back_ctrl.near_push  = 1'b1;
        end
        cdq_pkg::REQ_PUSH_FRONT: begin
          front_ctrl.near_push = 1'b1;
          back_ctrl.far_push   = 1'b1;
        end
        cdq_pkg::REQ_POP_BACK: begin
          front_ctrl.far_pop   = 1'b1;
          back_ctrl.near_pop   = 1'b1;
        end
        cdq_pkg::REQ_POP_FRONT: begin
          front_ctrl.near_pop  = 1'b1;
          back_ctrl.far_pop    = 1'b1;
        end
        default: begin
          front_ctrl = '0;
          back_ctrl  = '0;
        end
      endcase
    end
  end

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_front_chain (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (front_ctrl),
    .element         (element),
    .head_value      (fr_head_value),
    .head_valid      (fr_head_valid),
    .last_valid      (fr_last_valid),
    .head_value_next (fr_head_value_next),
    .head_valid_next (fr_head_valid_next),
    .last_valid_next (fr_last_valid_next)
  );

  cdq_chain #(
    .DEPTH (DEPTH)
  ) u_back_chain (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (back_ctrl),
    .element         (element),
    .head_value      (bk_head_value),
    .head_valid      (bk_head_valid),
    .last_valid      (bk_last_valid),
    .head_value_next (bk_head_value_next),
    .head_valid_next (),
    .last_valid_next ()
  );

  // Advance the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result of each accepted transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ok           <= req_ok;
      if (req_ok && (req_type == cdq_pkg::REQ_POP_FRONT)) begin
        popped_value <= fr_head_value;
      end else if (req_ok && (req_type == cdq_pkg::REQ_POP_BACK)) begin
        popped_value <= bk_head_value;
      end else begin
        popped_value <= '0;
      end
      front_value  <= fr_head_valid_next ? fr_head_value_next : '0;
      back_value   <= fr_head_valid_next ? bk_head_value_next : '0;
      is_empty     <= ~fr_head_valid_next;
      is_full      <= fr_last_valid_next;
    end
  end

  // Both rows must agree on whether the deque is empty
  a_rows_empty_agree: assert property (@(posedge clk) disable iff (rst)
    fr_head_valid == bk_head_valid)
    else $error("front and back rows disagree on occupancy of the first cell");

  // Both rows must agree on whether the deque is full
  a_rows_full_agree: assert property (@(posedge clk) disable iff (rst)
    fr_last_valid == bk_last_valid)
    else $error("front and back rows disagree on occupancy of the last cell");

  // A refused transaction leaves the occupancy unchanged
  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !req_ok) |=>
      ($stable(fr_head_valid) && $stable(fr_last_valid)))
    else $error("refused transaction changed the deque contents");

  // Every accepted transaction produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted transaction produced no result");

endmodule

`default_nettype wire
